FILE: src/prot_pkg.sv
// Shared types, widths and register codes for the point rotate and offset transform.
package prot_pkg;

    // Fixed-point layout: coordinates Q16.16, coefficients Q2.16.
    localparam int COORD_W   = 32;
    localparam int COEF_W    = 18;
    localparam int FRAC_W    = 16;

    // Rotation unit widths. Its inputs carry the widest intermediate (35 bits).
    localparam int ROT_IN_W  = 35;
    localparam int PROD_W    = ROT_IN_W + COEF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int ROT_OUT_W = SUM_W - FRAC_W;

    // Final offset add, one bit above the rotated value.
    localparam int OSUM_W    = ROT_OUT_W + 1;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef logic signed [COORD_W-1:0]   coord_t;
    typedef logic signed [COEF_W-1:0]    coef_t;
    typedef logic signed [ROT_IN_W-1:0]  rot_in_t;
    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [ROT_OUT_W-1:0] rot_out_t;
    typedef logic signed [OSUM_W-1:0]    osum_t;

    // Adding half an LSB before the arithmetic shift rounds to nearest,
    // with halves going toward plus infinity.
    localparam sum_t ROUND_HALF = sum_t'(1) <<< (FRAC_W - 1);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Register reset values.
    localparam coef_t  COS_RESET   = coef_t'(65536);
    localparam coef_t  SIN_RESET   = coef_t'(0);
    localparam coord_t SHIFT_RESET = coord_t'(0);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COS_X   = 3'd0,
        REG_SIN_X   = 3'd1,
        REG_COS_Y   = 3'd2,
        REG_SIN_Y   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } prot_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] moved_x;
        logic signed [COORD_W-1:0] moved_y;
        logic signed [COORD_W-1:0] moved_z;
        logic                      clipped;
    } prot_out_t;

    typedef struct packed {
        logic                      clip;
        logic signed [COORD_W-1:0] value;
    } sat_res_t;

endpackage

FILE: src/prot_rot.sv
// Two-stage pipelined plane rotation: (u*c - w*s, u*s + w*c), rounded to Q22.16.
module prot_rot (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  prot_pkg::rot_in_t        in_u,
    input  prot_pkg::rot_in_t        in_w,
    input  prot_pkg::coef_t          coef_c,
    input  prot_pkg::coef_t          coef_s,
    input  prot_pkg::rot_in_t        in_side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output prot_pkg::rot_out_t       out_re,
    output prot_pkg::rot_out_t       out_im,
    output prot_pkg::rot_in_t        out_side
);

    // Product stage.
    logic               prod_valid_reg;
    prot_pkg::prod_t    uc_reg, ws_reg, us_reg, wc_reg;
    prot_pkg::rot_in_t  prod_side_reg;
    prot_pkg::prod_t    uc_next, ws_next, us_next, wc_next;

    // Round stage.
    logic               rnd_valid_reg;
    prot_pkg::rot_out_t re_reg, im_reg;
    prot_pkg::rot_in_t  rnd_side_reg;
    prot_pkg::sum_t     re_sum, im_sum;
    prot_pkg::rot_out_t re_next, im_next;

    logic prod_adv, rnd_adv;

    // A stage loads when it is empty or when its content moves on.
    assign rnd_adv  = !rnd_valid_reg || out_ready;
    assign prod_adv = !prod_valid_reg || rnd_adv;
    assign in_ready = prod_adv;

    assign uc_next = prot_pkg::prod_t'(in_u) * prot_pkg::prod_t'(coef_c);
    assign ws_next = prot_pkg::prod_t'(in_w) * prot_pkg::prod_t'(coef_s);
    assign us_next = prot_pkg::prod_t'(in_u) * prot_pkg::prod_t'(coef_s);
    assign wc_next = prot_pkg::prod_t'(in_w) * prot_pkg::prod_t'(coef_c);

    assign re_sum  = prot_pkg::sum_t'(uc_reg) - prot_pkg::sum_t'(ws_reg) + prot_pkg::ROUND_HALF;
    assign im_sum  = prot_pkg::sum_t'(us_reg) + prot_pkg::sum_t'(wc_reg) + prot_pkg::ROUND_HALF;
    assign re_next = re_sum[prot_pkg::SUM_W-1:prot_pkg::FRAC_W];
    assign im_next = im_sum[prot_pkg::SUM_W-1:prot_pkg::FRAC_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            rnd_valid_reg  <= 1'b0;
        end else begin
            if (prod_adv) begin
                prod_valid_reg <= in_valid;
            end
            if (rnd_adv) begin
                rnd_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_adv) begin
            uc_reg        <= uc_next;
            ws_reg        <= ws_next;
            us_reg        <= us_next;
            wc_reg        <= wc_next;
            prod_side_reg <= in_side;
        end
        if (rnd_adv) begin
            re_reg       <= re_next;
            im_reg       <= im_next;
            rnd_side_reg <= prod_side_reg;
        end
    end

    assign out_valid = rnd_valid_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;
    assign out_side  = rnd_side_reg;

endmodule

FILE: src/point_rotate_offset_transform_top.sv
// Top level of the point rotate and offset transform: config registers and pipeline.
//
// Usage: a point (point_x, point_y, point_z), signed Q16.16, enters as one transaction
// on the s_ channel (s_valid/s_ready/s_data). It is rotated about X, then about Y,
// shifted by a per-axis offset and leaves as one transaction on the m_ channel
// (m_valid/m_ready/m_data) with each axis saturated to 32 bits and a clipped flag.
// The sines, cosines and offsets are written through the APB port beforehand,
// while no transaction is in flight; pready is always high.
//
// The block takes one transaction per clock while the receiver does not stall. A
// transaction passes in order through the five register stages: X-rotation
// products, X-rotation round, Y-rotation products, Y-rotation round, offset add
// and saturate; m_valid rises when it reaches the last.
// Every stage carries its own valid bit and loads whenever it is empty or its
// content moves on, so bubbles close up while the receiver stalls; s_ready drops
// only when all five stages hold a transaction and m_ready is low.
// Synchronous reset (aresetn low) empties the pipeline and restores the register
// defaults: unit cosines, zero sines and zero offsets.
module point_rotate_offset_transform_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Point input channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  prot_pkg::prot_in_t                   s_data,
    // Transformed point channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output prot_pkg::prot_out_t                  m_data,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [prot_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [prot_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [prot_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Index comes from the word address.
    // ------------------------------------------------------------------
    prot_pkg::coef_t  cos_x_reg, sin_x_reg, cos_y_reg, sin_y_reg;
    prot_pkg::coord_t shift_x_reg, shift_y_reg, shift_z_reg;
    prot_pkg::reg_idx_t reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = prot_pkg::reg_idx_t'(paddr[prot_pkg::APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_x_reg   <= prot_pkg::COS_RESET;
            sin_x_reg   <= prot_pkg::SIN_RESET;
            cos_y_reg   <= prot_pkg::COS_RESET;
            sin_y_reg   <= prot_pkg::SIN_RESET;
            shift_x_reg <= prot_pkg::SHIFT_RESET;
            shift_y_reg <= prot_pkg::SHIFT_RESET;
            shift_z_reg <= prot_pkg::SHIFT_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                prot_pkg::REG_COS_X:   cos_x_reg   <= pwdata[prot_pkg::COEF_W-1:0];
                prot_pkg::REG_SIN_X:   sin_x_reg   <= pwdata[prot_pkg::COEF_W-1:0];
                prot_pkg::REG_COS_Y:   cos_y_reg   <= pwdata[prot_pkg::COEF_W-1:0];
                prot_pkg::REG_SIN_Y:   sin_y_reg   <= pwdata[prot_pkg::COEF_W-1:0];
                prot_pkg::REG_SHIFT_X: shift_x_reg <= pwdata[prot_pkg::COORD_W-1:0];
                prot_pkg::REG_SHIFT_Y: shift_y_reg <= pwdata[prot_pkg::COORD_W-1:0];
                prot_pkg::REG_SHIFT_Z: shift_z_reg <= pwdata[prot_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the coefficients sign-extended to the bus width and the offsets as stored.
    always_comb begin
        case (reg_idx)
            prot_pkg::REG_COS_X:   prdata = prot_pkg::APB_DATA_W'(cos_x_reg);
            prot_pkg::REG_SIN_X:   prdata = prot_pkg::APB_DATA_W'(sin_x_reg);
            prot_pkg::REG_COS_Y:   prdata = prot_pkg::APB_DATA_W'(cos_y_reg);
            prot_pkg::REG_SIN_Y:   prdata = prot_pkg::APB_DATA_W'(sin_y_reg);
            prot_pkg::REG_SHIFT_X: prdata = prot_pkg::APB_DATA_W'(shift_x_reg);
            prot_pkg::REG_SHIFT_Y: prdata = prot_pkg::APB_DATA_W'(shift_y_reg);
            prot_pkg::REG_SHIFT_Z: prdata = prot_pkg::APB_DATA_W'(shift_z_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Rotation about X: a1 = R(y*c - z*s), a2 = R(y*s + z*c).
    // The X coordinate rides along as side data.
    // ------------------------------------------------------------------
    logic               rx_valid, rx_ready;
    prot_pkg::rot_out_t rx_a1, rx_a2;
    prot_pkg::rot_in_t  rx_x;

    prot_rot u_rot_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_u      (prot_pkg::rot_in_t'(s_data.point_y)),
        .in_w      (prot_pkg::rot_in_t'(s_data.point_z)),
        .coef_c    (cos_x_reg),
        .coef_s    (sin_x_reg),
        .in_side   (prot_pkg::rot_in_t'(s_data.point_x)),
        .out_valid (rx_valid),
        .out_ready (rx_ready),
        .out_re    (rx_a1),
        .out_im    (rx_a2),
        .out_side  (rx_x)
    );

    // ------------------------------------------------------------------
    // Rotation about Y: b0 = R(x*cy - a2*sy), b2 = R(x*sy + a2*cy).
    // The intermediates fit in 35 bits, so the truncation loses nothing.
    // a1 rides along as side data.
    // ------------------------------------------------------------------
    logic               ry_valid, ry_ready;
    prot_pkg::rot_out_t ry_b0, ry_b2;
    prot_pkg::rot_in_t  ry_a1;

    prot_rot u_rot_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rx_valid),
        .in_ready  (rx_ready),
        .in_u      (rx_x),
        .in_w      (rx_a2[prot_pkg::ROT_IN_W-1:0]),
        .coef_c    (cos_y_reg),
        .coef_s    (sin_y_reg),
        .in_side   (rx_a1[prot_pkg::ROT_IN_W-1:0]),
        .out_valid (ry_valid),
        .out_ready (ry_ready),
        .out_re    (ry_b0),
        .out_im    (ry_b2),
        .out_side  (ry_a1)
    );

    // ------------------------------------------------------------------
    // Offset add and saturation, registered on the output.
    // ------------------------------------------------------------------
    function automatic prot_pkg::sat_res_t sat_coord(input prot_pkg::osum_t v);
        prot_pkg::sat_res_t r;
        r.clip = 1'b1;
        if (v > prot_pkg::osum_t'(prot_pkg::COORD_MAX)) begin
            r.value = prot_pkg::COORD_MAX;
        end else if (v < prot_pkg::osum_t'(prot_pkg::COORD_MIN)) begin
            r.value = prot_pkg::COORD_MIN;
        end else begin
            r.clip  = 1'b0;
            r.value = v[prot_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    logic                out_adv;
    logic                m_valid_reg;
    prot_pkg::prot_out_t m_data_reg, m_data_next;
    prot_pkg::sat_res_t  sat_x, sat_y, sat_z;

    assign out_adv  = !m_valid_reg || m_ready;
    assign ry_ready = out_adv;

    always_comb begin
        sat_x = sat_coord(prot_pkg::osum_t'(ry_b0) + prot_pkg::osum_t'(shift_x_reg));
        sat_y = sat_coord(prot_pkg::osum_t'(ry_a1) + prot_pkg::osum_t'(shift_y_reg));
        sat_z = sat_coord(prot_pkg::osum_t'(ry_b2) + prot_pkg::osum_t'(shift_z_reg));
        m_data_next.moved_x = sat_x.value;
        m_data_next.moved_y = sat_y.value;
        m_data_next.moved_z = sat_z.value;
        m_data_next.clipped = sat_x.clip || sat_y.clip || sat_z.clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= ry_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input side may only stall when the whole pipeline is full and blocked.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && ry_valid && rx_valid))
        else $error("input stalled while the pipeline had room");

    // A clipped result carries a rail value on at least one axis.
    a_clip_has_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
            (m_data.moved_x == prot_pkg::COORD_MAX || m_data.moved_x == prot_pkg::COORD_MIN ||
             m_data.moved_y == prot_pkg::COORD_MAX || m_data.moved_y == prot_pkg::COORD_MIN ||
             m_data.moved_z == prot_pkg::COORD_MAX || m_data.moved_z == prot_pkg::COORD_MIN))
        else $error("clipped flag set without a saturated axis");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !ry_valid && !rx_valid))
        else $error("pipeline not empty after reset");

    // A result only appears when the Y rotation held one in the cycle before.
    a_ordered_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid)) |-> $past(ry_valid))
        else $error("output became valid without a rotated item behind it");

endmodule
